// ===== design/tws_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_pkg: shared types and codes of the tagged word stack
// Operation codes, status codes and the controller/datapath command structs.
// ----------------------------------------------------------------------------
package tws_pkg;

	localparam logic [2:0] FUNC_PUSH      = 3'd0;
	localparam logic [2:0] FUNC_PUSH_TRIM = 3'd1;
	localparam logic [2:0] FUNC_POP       = 3'd2;
	localparam logic [2:0] FUNC_POP_BYTE  = 3'd3;
	localparam logic [2:0] FUNC_POP_INT   = 3'd4;
	localparam logic [2:0] FUNC_PEEK      = 3'd5;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_EMPTY     = 2'd2;
	localparam logic [1:0] ST_NOT_BYTE  = 2'd3;

	localparam logic [63:0] INT_SAT     = 64'h0000_0000_0FFF_FFFF;
	localparam logic [63:0] BYTE_MAX    = 64'h0000_0000_0000_00FF;

	// controller -> datapath
	typedef struct packed {
		logic       load;     // capture input beat
		logic       wr;       // write captured value at wr slot
		logic       rd;       // read slot into read register
		logic       fmt;      // build result from read register
		logic       clr;      // build result with zero value
	} tws_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic       full;
		logic       empty;
		logic       bad_depth;
		logic       too_long;
	} tws_sts_t;

endpackage

// ===== design/tws_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_ctrl: sequencer of the tagged word stack
// Walks one beat through capture, memory access and result formatting.
// ----------------------------------------------------------------------------
module tws_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  logic [2:0]        func,
	input  tws_pkg::tws_sts_t sts,
	input  logic              out_free,
	output logic              in_ready,
	output tws_pkg::tws_cmd_t cmd
);
	import tws_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DEC  = 2'd1;
	localparam logic [1:0] S_RD   = 2'd2;
	localparam logic [1:0] S_OUT  = 2'd3;

	logic [1:0] state_q;
	logic [2:0] func_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			func_q  <= FUNC_PUSH;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_DEC;
						func_q  <= func;
					end
				end
				S_DEC: begin
					if ((func_q inside {FUNC_POP, FUNC_POP_BYTE, FUNC_POP_INT})
						&& !sts.empty)
						state_q <= S_RD;
					else if (func_q == FUNC_PEEK && !sts.bad_depth)
						state_q <= S_RD;
					else if (out_free)
						state_q <= S_IDLE;
				end
				S_RD:    state_q <= S_OUT;
				S_OUT:   if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	logic is_pop;
	assign is_pop = (func_q inside {FUNC_POP, FUNC_POP_BYTE, FUNC_POP_INT});

	always_comb begin
		cmd      = '0;
		in_ready = (state_q == S_IDLE);
		cmd.load = in_fire;
		case (state_q)
			S_DEC: begin
				if (is_pop && !sts.empty) begin
					cmd.rd = 1'b1;
				end else if (func_q == FUNC_PEEK && !sts.bad_depth) begin
					cmd.rd = 1'b1;
				end else if (out_free) begin
					cmd.clr = 1'b1;
					cmd.wr  = (func_q == FUNC_PUSH || func_q == FUNC_PUSH_TRIM)
						&& !sts.full && !sts.too_long;
				end
			end
			S_OUT:   cmd.fmt = out_free;
			default: ;
		endcase
	end

endmodule

// ===== design/tws_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_dp: storage and result datapath of the tagged word stack
// Holds the value and tag memories, the entry count and the output register.
// ----------------------------------------------------------------------------
module tws_dp #(
	parameter int STACK_DEPTH     = 1024,
	parameter int MAX_ENTRY_BYTES = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tws_pkg::tws_cmd_t cmd,
	input  logic [2:0]        func,
	input  logic [5:0]        length,
	input  logic [10:0]       depth_pos,
	input  logic [255:0]      word_in,
	output tws_pkg::tws_sts_t sts,
	output logic [1:0]        status,
	output logic [5:0]        stored_len,
	output logic [255:0]      value_out,
	output logic [10:0]       entries
);
	import tws_pkg::*;

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);

	logic [255:0] val_mem [STACK_DEPTH];
	logic [5:0]   tag_mem [STACK_DEPTH];

	logic [2:0]   func_q;
	logic [5:0]   len_q;
	logic [10:0]  depth_q;
	logic [255:0] word_q;
	logic [CW-1:0] count_q;
	logic [255:0] rd_val_q;
	logic [5:0]   rd_tag_q;

	// byte mask helper
	function automatic logic [255:0] keep_mask(input logic [6:0] n);
		logic [255:0] m;
		for (int b = 0; b < 32; b++)
			m[b*8 +: 8] = (7'(b) < n) ? 8'hFF : 8'h00;
		return m;
	endfunction

	// trimmed length of word0
	logic [5:0] trim_len;
	always_comb begin
		trim_len = 6'd1;
		for (int k = 1; k < 8; k++)
			if (word_q[63:0] >> (8 * k) != 64'd0)
				trim_len = 6'(k + 1);
	end

	logic        is_trim;
	logic [5:0]  push_len;
	logic [255:0] push_val;
	assign is_trim  = (func_q == FUNC_PUSH_TRIM);
	assign push_len = is_trim ? trim_len : len_q;
	assign push_val = (is_trim ? {192'd0, word_q[63:0]} : word_q)
		& keep_mask({1'b0, push_len});

	assign sts.full      = ({{(32-CW){1'b0}}, count_q} >= 32'(STACK_DEPTH));
	assign sts.too_long  = ({26'd0, push_len} > 32'(MAX_ENTRY_BYTES));
	assign sts.empty     = (count_q == '0);
	assign sts.bad_depth = (depth_q == 11'd0)
		|| ({21'd0, depth_q} > {{(32-CW){1'b0}}, count_q});

	logic [CW-1:0] rd_idx;
	logic          is_pop;
	assign is_pop = (func_q inside {FUNC_POP, FUNC_POP_BYTE, FUNC_POP_INT});
	assign rd_idx = is_pop ? (count_q - 1'b1) : (count_q - CW'(depth_q));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= func;
			len_q   <= length;
			depth_q <= depth_pos;
			word_q  <= word_in;
		end
		if (cmd.wr) begin
			val_mem[count_q[AW-1:0]] <= push_val;
			tag_mem[count_q[AW-1:0]] <= push_len;
		end
		if (cmd.rd) begin
			rd_val_q <= val_mem[rd_idx[AW-1:0]];
			rd_tag_q <= tag_mem[rd_idx[AW-1:0]];
		end
	end

	// result formatting
	logic [255:0] fmt_val;
	logic [1:0]   fmt_st;
	logic         hi_zero;
	assign hi_zero = (rd_val_q[255:64] == 192'd0);
	always_comb begin
		fmt_val = rd_val_q;
		fmt_st  = ST_OK;
		case (func_q)
			FUNC_POP: fmt_val = rd_val_q & keep_mask({1'b0, len_q});
			FUNC_POP_BYTE: begin
				if (rd_tag_q == 6'd0 || !hi_zero || rd_val_q[63:0] > BYTE_MAX) begin
					fmt_st  = ST_NOT_BYTE;
					fmt_val = '0;
				end
			end
			FUNC_POP_INT: begin
				if (!hi_zero || rd_val_q[63:0] > INT_SAT)
					fmt_val = {192'd0, INT_SAT};
			end
			default: ;
		endcase
	end

	logic pushing;
	assign pushing = (func_q == FUNC_PUSH || func_q == FUNC_PUSH_TRIM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			if (cmd.wr)
				count_q <= count_q + 1'b1;
			else if (cmd.rd && is_pop)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			value_out  <= '0;
			stored_len <= cmd.wr ? push_len : 6'd0;
			if (pushing)
				status <= cmd.wr ? ST_OK : ST_FULL;
			else if (is_pop || func_q == FUNC_PEEK)
				status <= ST_EMPTY;
			else
				status <= ST_OK;
			entries <= 11'(count_q + (cmd.wr ? 1'b1 : 1'b0));
		end else if (cmd.fmt) begin
			value_out  <= fmt_val;
			stored_len <= rd_tag_q;
			status     <= fmt_st;
			entries    <= 11'(count_q);
		end
	end

endmodule

// ===== design/tagged_word_stack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tagged_word_stack: operand stack of byte-length-tagged 256-bit values
// Top level joining the sequencer and the storage datapath.
// ----------------------------------------------------------------------------
// Usage:
//   The s_axis channel takes one operation per beat: func, length, depth_pos
//   and a 256-bit value. For every beat one result beat leaves on m_axis
//   with status, stored length tag, 256-bit value and the entry count.
//   Operations are handled one at a time. A push, a refused operation or an
//   unused func goes from decode straight to the output register; a pop or
//   peek that reads the memory passes the registered read of the value
//   memory and one spare slot before formatting. The input is ready again
//   in the same cycle the result is shown, so a new beat is taken only once
//   the last one has its result.
//   While the receiver stalls, the result holds in the output register. One
//   more beat may be taken and carried up to its result, which then waits
//   for the register to free; s_axis_tready stays low until it does.
//   Reset clears the entry count and the output valid flag; the memories
//   keep no reset, since only entries below the count are ever read.
// ----------------------------------------------------------------------------
module tagged_word_stack #(
	parameter int STACK_DEPTH     = 1024,
	parameter int MAX_ENTRY_BYTES = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// func[2:0], length[8:3], depth_pos[19:9], word3..word0 from bit 20 up
	input  logic [279:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// status[1:0], stored_len[7:2], out3..out0 from bit 8 up, entries[274:264]
	output logic [279:0] m_axis_tdata
);
	import tws_pkg::*;

	tws_cmd_t cmd;
	tws_sts_t sts;
	logic     in_fire;
	logic     out_free;
	logic     valid_q;

	logic [1:0]   status;
	logic [5:0]   stored_len;
	logic [255:0] value_out;
	logic [10:0]  entries;

	assign in_fire  = s_axis_tvalid && s_axis_tready;
	// result register is free once empty or taken this cycle
	assign out_free = !valid_q || m_axis_tready;

	tws_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.func     (s_axis_tdata[2:0]),
		.sts      (sts),
		.out_free (out_free),
		.in_ready (s_axis_tready),
		.cmd      (cmd)
	);

	tws_dp #(
		.STACK_DEPTH     (STACK_DEPTH),
		.MAX_ENTRY_BYTES (MAX_ENTRY_BYTES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.func       (s_axis_tdata[2:0]),
		.length     (s_axis_tdata[8:3]),
		.depth_pos  (s_axis_tdata[19:9]),
		// word0 is the low word of the value
		.word_in    ({s_axis_tdata[83:20], s_axis_tdata[147:84],
			s_axis_tdata[211:148], s_axis_tdata[275:212]}),
		.sts        (sts),
		.status     (status),
		.stored_len (stored_len),
		.value_out  (value_out),
		.entries    (entries)
	);

	// hold valid until the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			if (cmd.clr || cmd.fmt)
				valid_q <= 1'b1;
			else if (m_axis_tready)
				valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {5'd0, entries, value_out[63:0], value_out[127:64],
		value_out[191:128], value_out[255:192], stored_len, status};

endmodule

// ===== design/tws_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_checker: port-level checks of the tagged word stack
// Watches the stream handshakes and result fields over time.
// ----------------------------------------------------------------------------
module tws_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [279:0] m_axis_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped while stalled");

	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second beat taken during work");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[279:275] == 5'd0)
		else $error("result padding not zero");

	a_slen: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[7:2] <= 6'd32)
		else $error("length tag out of range");
endmodule

bind tagged_word_stack tws_checker u_tws_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the tagged word stack
// Feeds stack operations on the input stream in bursts, predicts every
// result beat with a shadow stack and compares each output beat field by
// field while the output side stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb;
	import tws_pkg::*;

	localparam int DEPTH     = 1024;
	localparam int MAX_BYTES = 32;
	localparam int LIMIT     = 400000;

	typedef struct packed {
		logic [1:0]   status;
		logic [5:0]   tag;
		logic [255:0] value;
		logic [10:0]  entries;
	} stack_result_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [279:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [279:0] m_axis_tdata;

	tagged_word_stack dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow stack
	logic [255:0]  shadow_value [DEPTH];
	logic [5:0]    shadow_tag [DEPTH];
	int            shadow_count = 0;

	logic [279:0]  op_queue [$];
	stack_result_t expected_results [$];
	int            errors = 0;
	int            results_seen = 0;
	int            cycles = 0;

	function automatic logic [255:0] keep_low_bytes(logic [255:0] v, int n);
		if (n >= 32)
			return v;
		return v & ((256'd1 << (8 * n)) - 256'd1);
	endfunction

	// apply one accepted operation to the shadow stack, return its result
	function automatic stack_result_t stack_apply(logic [279:0] beat);
		stack_result_t r;
		logic [2:0]    func;
		logic [5:0]    len;
		logic [10:0]   depth;
		logic [255:0]  v;
		int            n;
		func  = beat[2:0];
		len   = beat[8:3];
		depth = beat[19:9];
		v     = {beat[83:20], beat[147:84], beat[211:148], beat[275:212]};
		r     = '0;
		case (func)
			FUNC_PUSH, FUNC_PUSH_TRIM: begin
				if (func == FUNC_PUSH_TRIM) begin
					v = {192'd0, v[63:0]};
					n = 1;
					for (int k = 1; k < 8; k++)
						if ((v[63:0] >> (8 * k)) != 0)
							n = k + 1;
				end else begin
					n = len;
				end
				if (shadow_count >= DEPTH || n > MAX_BYTES) begin
					r.status = ST_FULL;
				end else begin
					shadow_value[shadow_count] = keep_low_bytes(v, n);
					shadow_tag[shadow_count] = n[5:0];
					shadow_count++;
					r.tag = n[5:0];
				end
			end
			FUNC_POP, FUNC_POP_BYTE, FUNC_POP_INT: begin
				if (shadow_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					shadow_count--;
					r.tag   = shadow_tag[shadow_count];
					r.value = shadow_value[shadow_count];
					if (func == FUNC_POP) begin
						r.value = keep_low_bytes(r.value, len);
					end else if (func == FUNC_POP_BYTE) begin
						if (r.tag == 0 || r.value > 256'(BYTE_MAX)) begin
							r.status = ST_NOT_BYTE;
							r.value  = '0;
						end
					end else if (r.value >= 256'h1000_0000) begin
						r.value = 256'(INT_SAT);
					end
				end
			end
			FUNC_PEEK: begin
				if (depth == 0 || depth > shadow_count) begin
					r.status = ST_EMPTY;
				end else begin
					r.tag   = shadow_tag[shadow_count - depth];
					r.value = shadow_value[shadow_count - depth];
				end
			end
			default: ;
		endcase
		r.entries = shadow_count[10:0];
		return r;
	endfunction

	function automatic logic [279:0] make_op(logic [2:0] func, logic [5:0] len,
			logic [10:0] depth, logic [255:0] v);
		return {4'd0, v[63:0], v[127:64], v[191:128], v[255:192], depth, len, func};
	endfunction

	// random value: a third full width, the rest short, near the byte and int limits or of random byte length
	function automatic logic [255:0] random_value();
		logic [255:0] v;
		v = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		case ($urandom_range(0, 5))
			0: v = v & 256'hFF;
			1: v = v & 256'h1FF;
			2: v = v & 256'h1FFF_FFFF;
			3: v = keep_low_bytes(v, $urandom_range(0, 32));
			default: ;
		endcase
		return v;
	endfunction

	function automatic logic [5:0] random_length();
		if ($urandom_range(0, 9) == 0)
			return 6'($urandom_range(33, 63));
		return 6'($urandom_range(0, 32));
	endfunction

	function automatic logic [279:0] random_op(int push_pct);
		logic [2:0]   func;
		logic [255:0] v;
		v = random_value();
		if ($urandom_range(1, 100) <= push_pct) begin
			func = ($urandom_range(0, 2) == 0) ? FUNC_PUSH_TRIM : FUNC_PUSH;
			if (func == FUNC_PUSH_TRIM)
				v[63:0] = {$urandom, $urandom} >> (8 * $urandom_range(0, 8));
		end else begin
			case ($urandom_range(0, 9))
				0, 1, 2: func = FUNC_POP;
				3, 4:    func = FUNC_POP_BYTE;
				5, 6:    func = FUNC_POP_INT;
				7, 8:    func = FUNC_PEEK;
				default: func = 3'($urandom_range(6, 7));
			endcase
		end
		return make_op(func, random_length(), ($urandom_range(0, 3) == 0) ?
				11'($urandom) : 11'($urandom_range(0, 12)), v);
	endfunction

	initial begin
		logic [255:0] ones;
		ones = '1;
		// directed: empty pops and peek, extremes of the fields, every func
		op_queue.push_back(make_op(FUNC_POP, 6'd32, 11'd0, '0));
		op_queue.push_back(make_op(FUNC_POP_BYTE, 6'd0, 11'd0, '0));
		op_queue.push_back(make_op(FUNC_POP_INT, 6'd0, 11'd0, '0));
		op_queue.push_back(make_op(FUNC_PEEK, 6'd0, 11'd1, '0));
		op_queue.push_back(make_op(FUNC_PUSH, 6'd33, 11'd0, ones));
		op_queue.push_back(make_op(FUNC_PUSH, 6'd63, 11'h7FF, ones));
		op_queue.push_back(make_op(FUNC_PUSH, 6'd32, 11'd0, ones));
		op_queue.push_back(make_op(FUNC_PUSH, 6'd0, 11'd0, ones));
		op_queue.push_back(make_op(FUNC_PUSH_TRIM, 6'd0, 11'd0, '0));
		op_queue.push_back(make_op(FUNC_PUSH_TRIM, 6'd0, 11'd0, ones));
		op_queue.push_back(make_op(FUNC_PUSH_TRIM, 6'd0, 11'd0, 256'h100));
		op_queue.push_back(make_op(FUNC_PEEK, 6'd0, 11'd0, '0));
		op_queue.push_back(make_op(FUNC_PEEK, 6'd0, 11'd5, '0));
		op_queue.push_back(make_op(FUNC_PEEK, 6'd0, 11'd6, '0));
		op_queue.push_back(make_op(FUNC_PEEK, 6'd0, 11'h7FF, '0));
		op_queue.push_back(make_op(3'd6, 6'h3F, 11'h7FF, ones));
		op_queue.push_back(make_op(3'd7, 6'd0, 11'd0, '0));
		op_queue.push_back(make_op(FUNC_POP_INT, 6'd0, 11'd0, '0));
		op_queue.push_back(make_op(FUNC_POP_BYTE, 6'd0, 11'd0, '0));
		op_queue.push_back(make_op(FUNC_POP_BYTE, 6'd0, 11'd0, '0));
		op_queue.push_back(make_op(FUNC_POP, 6'd5, 11'd0, '0));
		op_queue.push_back(make_op(FUNC_PUSH, 6'd4, 11'd0, 256'h0FFF_FFFF));
		op_queue.push_back(make_op(FUNC_POP_INT, 6'd0, 11'd0, '0));
		op_queue.push_back(make_op(FUNC_PUSH, 6'd4, 11'd0, 256'h1000_0000));
		op_queue.push_back(make_op(FUNC_POP_INT, 6'd0, 11'd0, '0));
		// random: push only until past full, then drain and wander
		for (int i = 0; i < 1150; i++)
			op_queue.push_back(random_op(100));
		for (int i = 0; i < 850; i++)
			op_queue.push_back(random_op(10));
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		wait (op_queue.size() == 0 && !s_axis_tvalid);
		wait (expected_results.size() == 0);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// sender: bursts of beats separated by random gaps
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_results.push_back(stack_apply(op_queue.pop_front()));
				burst_left--;
			end
			if (s_axis_tvalid && !s_axis_tready) begin
				// hold the offered beat
			end else if (burst_left <= 0) begin
				burst_left = $urandom_range(1, 40);
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				s_axis_tvalid <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (op_queue.size() > 0) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= op_queue[0];
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver: own stall pattern, plus one long hold-off to back up the input
	int stall_left = 0;
	int holdoff_left = 0;
	bit holdoff_done = 1'b0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (!holdoff_done && results_seen >= 500) begin
				holdoff_done = 1'b1;
				holdoff_left = 300;
			end
			if (holdoff_left > 0) begin
				holdoff_left--;
				m_axis_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if ((results_seen / 150) % 2 == 1 && $urandom_range(0, 3) == 0)
					stall_left = $urandom_range(1, 6);
			end
		end
	end

	// checker: compare every output beat with the oldest prediction
	always @(posedge clk) begin
		stack_result_t want;
		stack_result_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.status  = m_axis_tdata[1:0];
			got.tag     = m_axis_tdata[7:2];
			got.value   = {m_axis_tdata[71:8], m_axis_tdata[135:72],
					m_axis_tdata[199:136], m_axis_tdata[263:200]};
			got.entries = m_axis_tdata[274:264];
			results_seen++;
			if (expected_results.size() == 0) begin
				$display("%t unexpected result beat: %h", $realtime, m_axis_tdata);
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (got.status !== want.status) begin
					$display("%t status: expected %0d actual %0d", $realtime,
							want.status, got.status);
					errors++;
				end
				if (got.tag !== want.tag) begin
					$display("%t stored_len: expected %0d actual %0d", $realtime,
							want.tag, got.tag);
					errors++;
				end
				if (got.value !== want.value) begin
					$display("%t value: expected %h actual %h", $realtime,
							want.value, got.value);
					errors++;
				end
				if (got.entries !== want.entries) begin
					$display("%t entries: expected %0d actual %0d", $realtime,
							want.entries, got.entries);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("%t timeout", $realtime);
			$display("status: fail");
			$finish;
		end
	end

endmodule
